@@ design/byte_ring_packetizer_assert.svh @@
// assertion macros used by the port-level checker
// depends on nothing; included by brp_checker.sv
`ifndef BYTE_RING_PACKETIZER_ASSERT_SVH
`define BYTE_RING_PACKETIZER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define BRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte ring packetizer check failed");

// next-cycle implication, quiet during reset
`define BRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte ring packetizer check failed");

`endif

@@ design/brp_pkg.sv @@
// shared types and codes of the byte ring packetizer
// depends on nothing
`timescale 1ns / 1ps

package brp_pkg;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_PACKET = 2'd1,
    KIND_BUSY   = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  typedef struct packed {
    kind_t        kind;
    logic [7:0]   packet_byte;
    logic         last;
    logic         accepted;
    logic [11:0]  free_slots;
    logic [31:0]  drop_count;
  } result_t;

endpackage

@@ design/brp_ram.sv @@
// generic single-write, single-read synchronous ram with registered read
// depends on nothing
`timescale 1ns / 1ps

module brp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/brp_obuf.sv @@
// two-entry result buffer between the ring datapath and the output channel
// depends on brp_pkg
`timescale 1ns / 1ps

module brp_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  brp_pkg::result_t push_res,
  input  logic             pop,
  output logic             head_valid,
  output brp_pkg::result_t head_res,
  output logic [1:0]       count
);

  brp_pkg::result_t slot_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop  ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_res;
    end
  end

  assign head_valid = (cnt_r != 2'd0);
  assign head_res   = slot_r[rptr_r];
  assign count      = cnt_r;

endmodule

@@ design/byte_ring_packetizer.sv @@
// top level of the byte ring packetizer: pointers, drain sequencer, ring ram
// depends on brp_pkg, brp_ram, brp_obuf
`timescale 1ns / 1ps

//  channel | direction | beat contents
//  --------+-----------+------------------------------------------------------
//  in_     | input     | opcode, push_byte, radio_full
//  out_    | output    | kind, packet_byte, last, accepted, free_slots, drop_count
//
//  a push or a refused drain is taken in and yields one status beat
//  an accepted drain sizes the packet as it is taken, then yields PACKET_BYTES
//  packet beats, one per cycle while the result buffer has room; ring bytes
//  are read from the ring ram, zero padding after; no input is taken during a drain
//  reset clears pointers, counters and buffers; the ring ram is not cleared
//  output stalls backpressure the drain through a two-entry result buffer

module byte_ring_packetizer #(
  parameter int RING_DEPTH   = 2048,
  parameter int PACKET_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_push_byte,
  input  logic        in_radio_full,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_packet_byte,
  output logic        out_last,
  output logic        out_accepted,
  output logic [11:0] out_free_slots,
  output logic [31:0] out_drop_count
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int SW = $clog2(RING_DEPTH + 1);
  localparam int CW = $clog2(PACKET_BYTES + 1);
  localparam int MW = (SW > CW) ? SW : CW;

  // wrap a pointer at the ring depth
  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
    return (p == AW'(RING_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  brp_pkg::state_t  state_r, state_nxt;
  logic [AW-1:0]    wr_r, wr_nxt;
  logic [AW-1:0]    rd_r, rd_nxt;
  logic [SW-1:0]    space_r, space_nxt;
  logic [31:0]      drop_r, drop_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;     // packet beat index
  logic [CW-1:0]    fill_r, fill_nxt;   // ring bytes in this packet

  // result stage that lines up with the ram read latency
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_ram_r, s1_ram_nxt;
  brp_pkg::result_t s1_res_r, s1_res_nxt;
  brp_pkg::result_t buf_in;

  logic             ram_we, ram_re;
  logic [7:0]       ram_rdata;
  logic             in_fire, out_fire;
  logic [1:0]       buf_count;
  logic [2:0]       occ;
  logic             credit;
  logic             ring_empty, ring_full;
  logic [AW-1:0]    wr_inc;
  logic [SW-1:0]    queued;
  logic [CW-1:0]    fill_calc;
  logic             head_valid;
  brp_pkg::result_t head_res;

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;

  // room for one more beat counting the one in flight and the one leaving
  assign occ    = 3'(buf_count) + 3'(s1_valid_r) - 3'(out_fire);
  assign credit = (occ < 3'd2);

  assign wr_inc     = advance(wr_r);
  assign ring_empty = (rd_r == wr_r);
  assign ring_full  = (wr_inc == rd_r);
  assign queued     = SW'(RING_DEPTH) - space_r;
  assign fill_calc  = (MW'(queued) >= MW'(PACKET_BYTES)) ? CW'(PACKET_BYTES) : CW'(queued);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brp_pkg::ST_IDLE: begin
        if (in_fire && in_opcode == brp_pkg::OP_DRAIN && !ring_empty && !in_radio_full) begin
          state_nxt = brp_pkg::ST_DRAIN;
        end
      end
      brp_pkg::ST_DRAIN: begin
        if (credit && cnt_r == CW'(PACKET_BYTES - 1)) begin
          state_nxt = brp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = brp_pkg::ST_IDLE;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    wr_nxt       = wr_r;
    rd_nxt       = rd_r;
    space_nxt    = space_r;
    drop_nxt     = drop_r;
    cnt_nxt      = cnt_r;
    fill_nxt     = fill_r;
    s1_valid_nxt = 1'b0;
    s1_ram_nxt   = 1'b0;
    s1_res_nxt   = s1_res_r;
    unique case (state_r)
      brp_pkg::ST_IDLE: begin
        in_ready = credit;
        if (in_fire) begin
          s1_valid_nxt           = 1'b1;
          s1_res_nxt.packet_byte = 8'd0;
          s1_res_nxt.last        = 1'b1;
          s1_res_nxt.accepted    = 1'b0;
          if (in_opcode == brp_pkg::OP_PUSH) begin
            s1_res_nxt.kind = brp_pkg::KIND_PUSH;
            if (ring_full) begin
              // dropped byte, saturating count
              if (drop_r != '1) begin
                drop_nxt = drop_r + 32'd1;
              end
            end else begin
              ram_we              = 1'b1;
              wr_nxt              = wr_inc;
              space_nxt           = space_r - SW'(1);
              s1_res_nxt.accepted = 1'b1;
            end
          end else if (ring_empty) begin
            s1_res_nxt.kind = brp_pkg::KIND_EMPTY;
          end else if (in_radio_full) begin
            s1_res_nxt.kind = brp_pkg::KIND_BUSY;
          end else begin
            // packet accepted: no beat now, space is final for every beat
            s1_valid_nxt = 1'b0;
            cnt_nxt      = '0;
            fill_nxt     = fill_calc;
            space_nxt    = space_r + SW'(fill_calc);
          end
          s1_res_nxt.free_slots = 12'(space_nxt);
          s1_res_nxt.drop_count = drop_nxt;
        end
      end
      brp_pkg::ST_DRAIN: begin
        if (credit) begin
          s1_valid_nxt           = 1'b1;
          s1_res_nxt.kind        = brp_pkg::KIND_PACKET;
          s1_res_nxt.packet_byte = 8'd0;
          s1_res_nxt.last        = (cnt_r == CW'(PACKET_BYTES - 1));
          s1_res_nxt.accepted    = 1'b0;
          s1_res_nxt.free_slots  = 12'(space_r);
          s1_res_nxt.drop_count  = drop_r;
          // ring bytes first, zero padding after
          if (cnt_r < fill_r) begin
            ram_re     = 1'b1;
            s1_ram_nxt = 1'b1;
            rd_nxt     = advance(rd_r);
          end
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= brp_pkg::ST_IDLE;
      wr_r       <= '0;
      rd_r       <= '0;
      space_r    <= SW'(RING_DEPTH);
      drop_r     <= '0;
      cnt_r      <= '0;
      fill_r     <= '0;
      s1_valid_r <= 1'b0;
      s1_ram_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wr_r       <= wr_nxt;
      rd_r       <= rd_nxt;
      space_r    <= space_nxt;
      drop_r     <= drop_nxt;
      cnt_r      <= cnt_nxt;
      fill_r     <= fill_nxt;
      s1_valid_r <= s1_valid_nxt;
      s1_ram_r   <= s1_ram_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_res_r <= s1_res_nxt;
  end

  // ram data joins the result stage in the cycle after the read
  always_comb begin
    buf_in = s1_res_r;
    if (s1_ram_r) begin
      buf_in.packet_byte = ram_rdata;
    end
  end

  brp_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_r),
    .wdata (in_push_byte),
    .re    (ram_re),
    .raddr (rd_r),
    .rdata (ram_rdata)
  );

  brp_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_valid_r),
    .push_res   (buf_in),
    .pop        (out_fire),
    .head_valid (head_valid),
    .head_res   (head_res),
    .count      (buf_count)
  );

  assign out_valid       = head_valid;
  assign out_kind        = head_res.kind;
  assign out_packet_byte = head_res.packet_byte;
  assign out_last        = head_res.last;
  assign out_accepted    = head_res.accepted;
  assign out_free_slots  = head_res.free_slots;
  assign out_drop_count  = head_res.drop_count;

endmodule

@@ design/brp_checker.sv @@
// port-level checks of the byte ring packetizer, bound to the top level
// depends on brp_pkg and byte_ring_packetizer_assert.svh
`timescale 1ns / 1ps
`include "byte_ring_packetizer_assert.svh"

module brp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_packet_byte,
  input logic        out_last,
  input logic        out_accepted,
  input logic [11:0] out_free_slots,
  input logic [31:0] out_drop_count
);

  logic out_stall;
  logic status_beat;

  assign out_stall   = out_valid & !out_ready;
  assign status_beat = out_valid & (out_kind != 2'(brp_pkg::KIND_PACKET));

  // a stalled beat stays valid and holds its byte, free slots and drop count
  `BRP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_packet_byte) && $stable(out_free_slots) && $stable(out_drop_count))

  // status beats end their input and carry no byte
  `BRP_ASSERT_IMPL(a_status_last, clk, rst_n, status_beat, out_last && out_packet_byte == 8'd0)

  // only a push status can report a stored byte
  `BRP_ASSERT_IMPL(a_acc_push, clk, rst_n, out_valid && out_accepted, out_kind == 2'(brp_pkg::KIND_PUSH))

  // a dropped push reports at most one free slot in the ring
  `BRP_ASSERT_IMPL(a_drop_full, clk, rst_n, out_valid && out_kind == 2'(brp_pkg::KIND_PUSH) && !out_accepted, out_free_slots == 12'(1) || out_free_slots == 12'(0))

endmodule

bind byte_ring_packetizer brp_checker u_brp_checker (.*);
